@@ rtl/core/dmd_pkg.sv @@
// ----------------------------------------------------------------------------
// dmd_pkg
// Shared constants, types and codes for the delimited message deframer.
// ----------------------------------------------------------------------------
package dmd_pkg;

	// frame buffer depth in bytes, start byte included
	localparam int FRAME_DEPTH = 64;
	// width of the stored byte count (must hold FRAME_DEPTH itself)
	localparam int CNT_W = $clog2(FRAME_DEPTH + 1);
	// width of a buffer address
	localparam int ADDR_W = $clog2(FRAME_DEPTH);

	// framing bytes
	localparam logic [7:0] BYTE_SOH   = 8'h01;
	localparam logic [7:0] BYTE_STX   = 8'h02;
	localparam logic [7:0] BYTE_ETX   = 8'h03;
	localparam logic [7:0] BYTE_SPACE = 8'h20;
	localparam logic [7:0] BYTE_UP_A  = 8'h41;
	localparam logic [7:0] BYTE_UP_Z  = 8'h5A;
	localparam logic [7:0] CASE_DELTA = 8'h20;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CHECK,
		S_FINAL
	} dmd_state_t;

	// verdict of the character unit on one stored byte
	typedef struct packed {
		logic       emit;      // byte yields a result
		logic       to_value;  // byte is the id/value separator
		logic [7:0] ch;        // character after normalization
	} char_class_t;

endpackage

@@ rtl/core/dmd_ram.sv @@
// ----------------------------------------------------------------------------
// dmd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dmd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/dmd_char_unit.sv @@
// ----------------------------------------------------------------------------
// dmd_char_unit
// Classifies one stored byte: separator, dropped value space or emitted character,
// with value characters folded to lower case.
// ----------------------------------------------------------------------------
module dmd_char_unit
	import dmd_pkg::*;
(
	input  logic [7:0]  byte_in,
	input  logic        in_val,
	output char_class_t verdict
);

	logic is_sep;
	logic is_space;
	logic is_upper;

	// byte compares
	always_comb begin
		is_sep   = !in_val && (byte_in == BYTE_STX);
		is_space = in_val && (byte_in == BYTE_SPACE);
		is_upper = (byte_in >= BYTE_UP_A) && (byte_in <= BYTE_UP_Z);
	end

	// verdict and lowercase folding
	always_comb begin
		verdict.emit     = !is_sep && !is_space;
		verdict.to_value = is_sep;
		verdict.ch       = (in_val && is_upper) ? (byte_in + CASE_DELTA) : byte_in;
	end

endmodule

@@ rtl/core/delimited_message_deframer.sv @@
// ----------------------------------------------------------------------------
// delimited_message_deframer
// Finds SOH, id, STX, value, ETX frames in a byte stream and replays each
// completed frame as one character per output transfer.
// ----------------------------------------------------------------------------
//
// channel  signals                                    direction
// -------  -----------------------------------------  ---------
// in       in_valid, in_ready, data_byte              into block
// out      out_valid, out_ready, char_out, in_value,  out of block
//          empty_message, last
//
// Inside a frame, a byte other than SOH or ETX is written to the frame buffer; a byte that
// finds the buffer full drops the frame. An ETX starts a replay: the sequencer reads the
// buffer once per stored byte through the single read port and the shared character unit,
// waiting while the output register is full and out_ready is low. in_ready is low for the whole replay.
// Reset clears the byte count and the frame flag; the buffer itself is never cleared,
// only bytes below the count are read.
module delimited_message_deframer
	import dmd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] char_out,
	output logic       in_value,
	output logic       empty_message,
	output logic       last
);

	dmd_state_t  state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic        inside_q, inside_d;
	logic        val_q, val_d;
	logic        pend_q, pend_d;
	logic [7:0]  pend_ch_q, pend_ch_d;
	logic        pend_val_q, pend_val_d;

	logic        out_valid_q;
	logic [7:0]  char_q;
	logic        in_value_q;
	logic        empty_q;
	logic        last_q;

	logic        out_load;
	logic [7:0]  load_ch;
	logic        load_val;
	logic        load_empty;
	logic        load_last;

	logic        wr_en;
	logic [7:0]  rd_data;
	char_class_t verdict;
	logic        out_free;
	logic        in_xfer;

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// frame buffer
	dmd_ram #(
		.WIDTH(8),
		.DEPTH(FRAME_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (data_byte),
		.raddr (idx_q[ADDR_W-1:0]),
		.rdata (rd_data)
	);

	// shared character classifier
	dmd_char_unit u_char (
		.byte_in (rd_data),
		.in_val  (val_q),
		.verdict (verdict)
	);

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			inside_q <= 1'b0;
			val_q    <= 1'b0;
			pend_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			idx_q    <= idx_d;
			inside_q <= inside_d;
			val_q    <= val_d;
			pend_q   <= pend_d;
		end
	end

	// held character payload
	always_ff @(posedge clk) begin
		pend_ch_q  <= pend_ch_d;
		pend_val_q <= pend_val_d;
	end

	// sequencer: byte capture and frame replay
	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		idx_d      = idx_q;
		inside_d   = inside_q;
		val_d      = val_q;
		pend_d     = pend_q;
		pend_ch_d  = pend_ch_q;
		pend_val_d = pend_val_q;
		wr_en      = 1'b0;
		out_load   = 1'b0;
		load_ch    = pend_ch_q;
		load_val   = pend_val_q;
		load_empty = 1'b0;
		load_last  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					priority if (data_byte == BYTE_SOH) begin
						count_d  = CNT_W'(1);
						inside_d = 1'b1;
					end else if (!inside_q) begin
						inside_d = 1'b0;
					end else if (data_byte == BYTE_ETX) begin
						inside_d = 1'b0;
						idx_d    = CNT_W'(1);
						val_d    = 1'b0;
						pend_d   = 1'b0;
						state_d  = S_READ;
					end else if (count_q >= CNT_W'(FRAME_DEPTH)) begin
						inside_d = 1'b0;
						count_d  = '0;
					end else begin
						wr_en   = 1'b1;
						count_d = count_q + CNT_W'(1);
					end
				end
			end
			S_READ: begin
				// read address idx_q is presented to the buffer this cycle
				if (idx_q < count_q) begin
					state_d = S_CHECK;
				end else begin
					state_d = S_FINAL;
				end
			end
			S_CHECK: begin
				if (verdict.to_value) begin
					val_d   = 1'b1;
					idx_d   = idx_q + CNT_W'(1);
					state_d = S_READ;
				end else if (!verdict.emit) begin
					idx_d   = idx_q + CNT_W'(1);
					state_d = S_READ;
				end else if (!pend_q) begin
					pend_d     = 1'b1;
					pend_ch_d  = verdict.ch;
					pend_val_d = val_q;
					idx_d      = idx_q + CNT_W'(1);
					state_d    = S_READ;
				end else if (out_free) begin
					// a later character exists, so the held one is not last
					out_load   = 1'b1;
					pend_ch_d  = verdict.ch;
					pend_val_d = val_q;
					idx_d      = idx_q + CNT_W'(1);
					state_d    = S_READ;
				end
			end
			S_FINAL: begin
				if (out_free) begin
					out_load  = 1'b1;
					load_last = 1'b1;
					if (!pend_q) begin
						load_ch    = 8'h00;
						load_val   = 1'b0;
						load_empty = 1'b1;
					end
					pend_d  = 1'b0;
					count_d = '0;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			char_q     <= load_ch;
			in_value_q <= load_val;
			empty_q    <= load_empty;
			last_q     <= load_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign char_out      = char_q;
	assign in_value      = in_value_q;
	assign empty_message = empty_q;
	assign last          = last_q;

endmodule

@@ dv/delimited_message_deframer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_message_deframer_tb
// Feeds start/separator/end framed byte streams into the deframer, predicts
// the replayed characters with a scoreboard and checks every output transfer
// in order, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module delimited_message_deframer_tb
	import dmd_pkg::*;
;

	localparam int          ITEMS_TARGET = 270;
	localparam int          LONG_HOLD    = 300;
	localparam int          TAIL_CYCLES  = 2 * FRAME_DEPTH + 16;
	localparam int unsigned STALL_LIMIT  = 2000;

	// opening sequence: stray bytes, empty frame, case folding and space
	// removal, zero byte, second separator, restart, separator missing
	localparam logic [7:0] OPENING [30] = '{
		8'hFF, BYTE_ETX,
		BYTE_SOH, BYTE_ETX,
		BYTE_SOH, 8'h49, 8'h00, BYTE_STX, BYTE_UP_A, BYTE_SPACE, BYTE_UP_Z,
		BYTE_STX, 8'h7A, BYTE_ETX,
		BYTE_SOH, 8'h71, BYTE_SOH, BYTE_STX, BYTE_SPACE, BYTE_SPACE, BYTE_ETX,
		BYTE_SOH, BYTE_STX, 8'h40, 8'h5B, BYTE_ETX,
		BYTE_SOH, 8'h51, BYTE_SPACE, BYTE_ETX
	};

	// one replayed character as it leaves the block
	typedef struct packed {
		logic [7:0] ch;
		logic       in_val;
		logic       is_empty;
		logic       lst;
	} deframed_char_t;

	// frame predictor and store of pending characters
	class frame_scoreboard;
		logic [7:0]     frame_buf [FRAME_DEPTH];
		int unsigned    byte_count;
		bit             framing;
		deframed_char_t pending [$];
		int unsigned    mismatches;
		int unsigned    chars_checked;
		int unsigned    frames_done;
		int unsigned    frames_dropped;
		int unsigned    empty_frames;

		task report(input string msg);
			mismatches++;
			if (mismatches <= 30)
				$display("mismatch: %s", msg);
		endtask

		// returns 1 when the byte matters to the framer
		function bit note_byte(input logic [7:0] b);
			logic [7:0] c;
			bit         to_value;
			int         first;
			if (b == BYTE_SOH) begin
				frame_buf[0] = b;
				byte_count = 1;
				framing = 1'b1;
				return 1'b1;
			end
			if (!framing)
				return 1'b0;
			// end byte: replay the stored frame
			if (b == BYTE_ETX) begin
				framing = 1'b0;
				frames_done++;
				first = pending.size();
				to_value = 1'b0;
				for (int i = 1; i < byte_count; i++) begin
					c = frame_buf[i];
					if (!to_value) begin
						if (c == BYTE_STX)
							to_value = 1'b1;
						else
							pending.push_back(deframed_char_t'{c, 1'b0, 1'b0, 1'b0});
					end else if (c != BYTE_SPACE) begin
						if (c >= BYTE_UP_A && c <= BYTE_UP_Z)
							c = c + CASE_DELTA;
						pending.push_back(deframed_char_t'{c, 1'b1, 1'b0, 1'b0});
					end
				end
				if (pending.size() == first) begin
					pending.push_back(deframed_char_t'{8'h00, 1'b0, 1'b1, 1'b0});
					empty_frames++;
				end
				pending[pending.size() - 1].lst = 1'b1;
				byte_count = 0;
				return 1'b1;
			end
			// store full: frame is thrown away
			if (byte_count >= FRAME_DEPTH) begin
				framing = 1'b0;
				byte_count = 0;
				frames_dropped++;
				return 1'b1;
			end
			frame_buf[byte_count] = b;
			byte_count++;
			return 1'b1;
		endfunction

		task check_char(input logic [7:0] ch, input logic in_val, input logic is_empty,
				input logic lst);
			deframed_char_t want;
			if (pending.size() == 0) begin
				report($sformatf("char %02h value %b empty %b last %b with nothing pending",
					ch, in_val, is_empty, lst));
				return;
			end
			want = pending.pop_front();
			chars_checked++;
			if ({ch, in_val, is_empty, lst} !== want)
				report($sformatf("got char %02h value %b empty %b last %b, want %02h %b %b %b",
					ch, in_val, is_empty, lst, want.ch, want.in_val, want.is_empty,
					want.lst));
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] data_byte;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] char_out;
	logic       in_value;
	logic       empty_message;
	logic       last;

	frame_scoreboard sb = new();
	bit              steady_phase;
	bit              hold_out;
	int unsigned     bytes_used;

	delimited_message_deframer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.char_out      (char_out),
		.in_value      (in_value),
		.empty_message (empty_message),
		.last          (last)
	);

	always #6 clk = ~clk;

	// random frame content, never a start or end byte
	function automatic logic [7:0] pick_char();
		logic [7:0] c;
		case ($urandom_range(0, 7))
			0: c = BYTE_UP_A + 8'($urandom_range(0, 25));
			1: c = BYTE_UP_A + CASE_DELTA + 8'($urandom_range(0, 25));
			2: c = BYTE_SPACE;
			3: c = BYTE_STX;
			default: c = 8'($urandom_range(0, 255));
		endcase
		if (c == BYTE_SOH || c == BYTE_ETX)
			c = c ^ 8'h80;
		return c;
	endfunction

	// one input transfer, starts and ends just after a falling edge
	task automatic send_byte(input logic [7:0] b);
		if (!steady_phase && $urandom_range(0, 5) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_valid  = 1'b1;
		data_byte = b;
		do @(posedge clk); while (!in_ready);
		if (sb.note_byte(b))
			bytes_used++;
		@(negedge clk);
	endtask

	task automatic send_frame(input int id_len, input bit with_sep, input int val_len,
			input bit closed);
		send_byte(BYTE_SOH);
		repeat (id_len) send_byte(pick_char());
		if (with_sep)
			send_byte(BYTE_STX);
		repeat (val_len) send_byte(pick_char());
		if (closed)
			send_byte(BYTE_ETX);
	endtask

	// output side: random stall bursts, one long hold on request
	initial begin : receiver
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_out) begin
				out_ready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_out  = 1'b0;
				out_ready = 1'b1;
			end else if (!steady_phase && $urandom_range(0, 4) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
				out_ready = 1'b1;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// check each output transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_char(char_out, in_value, empty_message, last);
	end

	// end the run when nothing moves for too long
	initial begin : watchdog
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		int unsigned frame_no;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		data_byte    = 8'h00;
		steady_phase = 1'b0;
		hold_out     = 1'b0;
		bytes_used   = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		foreach (OPENING[i])
			send_byte(OPENING[i]);

		// random frames, mostly well formed
		frame_no = 0;
		while (bytes_used < ITEMS_TARGET) begin
			if (bytes_used + 40 >= ITEMS_TARGET)
				steady_phase = 1'b1;
			case (frame_no)
				// exactly fills the store, longest replay
				2: send_frame(20, 1'b1, 42, 1'b1);
				// output held off while more bytes are offered
				4: begin
					hold_out = 1'b1;
					send_frame(6, 1'b1, 8, 1'b1);
				end
				// one byte past the store, frame dropped
				5: send_frame(30, 1'b1, 33, 1'b1);
				// let the block drain before going on
				8: begin
					in_valid = 1'b0;
					while (sb.pending.size() != 0) @(negedge clk);
					send_frame(3, 1'b1, 4, 1'b1);
				end
				default: begin
					case ($urandom_range(0, 9))
						0: repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
						1: send_frame($urandom_range(0, 5), 1'($urandom_range(0, 1)),
							$urandom_range(0, 5), 1'b0);
						default: send_frame($urandom_range(0, 6), $urandom_range(0, 3) != 0,
							$urandom_range(0, 8), 1'b1);
					endcase
				end
			endcase
			frame_no++;
		end
		in_valid = 1'b0;

		// drain, then watch for stray output
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (sb.pending.size() != 0)
			sb.report($sformatf("%0d characters never arrived", sb.pending.size()));

		$display("sent %0d frame bytes: %0d frames replayed, %0d empty, %0d dropped when full",
			bytes_used, sb.frames_done, sb.empty_frames, sb.frames_dropped);
		$display("checked %0d characters, %0d mismatches", sb.chars_checked, sb.mismatches);
		if (sb.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/dmd_pkg.sv
rtl/core/dmd_ram.sv
rtl/core/dmd_char_unit.sv
rtl/core/delimited_message_deframer.sv
dv/delimited_message_deframer_tb.sv
